[src/gsa_pkg.sv]
// shared types, constants and the weight lookup of the global sequence aligner
package gsa_pkg;

  localparam int MAX_LEN   = 32;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int BUF_DEPTH = 2 * MAX_LEN;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int POS_W     = $clog2(BUF_DEPTH + 1);
  localparam int DIR_DEPTH = MAX_LEN * MAX_LEN;
  localparam int DIR_AW    = 2 * IDX_W;
  localparam int SCORE_W   = 14;
  localparam int APB_AW    = 5;

  typedef logic signed [SCORE_W-1:0] score_t;

  typedef enum logic [1:0] {
    REQ_LONG  = 2'd0,
    REQ_SHORT = 2'd1,
    REQ_ALIGN = 2'd2,
    REQ_RSVD  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    REG_GAP    = 2'd0,
    REG_W_AT   = 2'd1,
    REG_W_GC   = 2'd2,
    REG_TB_DIR = 2'd3
  } reg_idx_e;

  localparam logic [1:0] ST_COLUMN   = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;

  localparam logic [2:0] GAP_SYM = 3'd4;

  localparam logic [63:0] W_AT_RESET = 64'h0000_0100_0000_0001;
  localparam logic [63:0] W_GC_RESET = 64'h0100_0000_0001_0000;

  typedef enum logic [1:0] {
    DIR_DIAG = 2'd0,
    DIR_LEFT = 2'd1,
    DIR_UP   = 2'd2
  } dir_e;

  typedef struct packed {
    score_t score;
    dir_e   dir;
  } cell_res_t;

  // signed byte weight for a short-sequence base s against a long-sequence base l
  function automatic logic signed [7:0] weight_of(logic [63:0] w_at, logic [63:0] w_gc,
                                                  logic [1:0] s, logic [1:0] l);
    logic [63:0] row_v;
    logic [2:0]  sel;
    row_v = s[1] ? w_gc : w_at;
    sel   = {s[0], l};
    return row_v[{sel, 3'b000} +: 8];
  endfunction

endpackage

[src/gsa_score_alu.sv]
// shared scoring unit: one matrix cell from diagonal, left and upper neighbours
module gsa_score_alu (
  input  gsa_pkg::score_t    diag_i,
  input  gsa_pkg::score_t    left_i,
  input  gsa_pkg::score_t    up_i,
  input  logic signed [7:0]  weight_i,
  input  logic [6:0]         gap_i,
  output gsa_pkg::cell_res_t res_o
);
  import gsa_pkg::*;

  logic signed [SCORE_W:0] d_s, lf_s, up_s, g_s;

  assign g_s  = (SCORE_W + 1)'(gap_i);
  assign d_s  = (SCORE_W + 1)'(diag_i) + (SCORE_W + 1)'(weight_i);
  assign lf_s = (SCORE_W + 1)'(left_i) - g_s;
  assign up_s = (SCORE_W + 1)'(up_i) - g_s;

  always_comb begin
    if (d_s > lf_s && d_s > up_s) begin
      res_o.dir   = DIR_DIAG;
      res_o.score = d_s[SCORE_W-1:0];
    end else if (lf_s >= up_s) begin
      res_o.dir   = DIR_LEFT;
      res_o.score = lf_s[SCORE_W-1:0];
    end else begin
      res_o.dir   = DIR_UP;
      res_o.score = up_s[SCORE_W-1:0];
    end
  end

endmodule

[src/global_sequence_aligner_top.sv]
// top level of the global sequence aligner: loader, fill, traceback and emitter
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | sink      | in_valid_i / in_ready_o | req_type_i, base_i
//  out     | source    | out_valid_o/out_ready_i | col_long_o, col_short_o, best_score_o,
//          |           |                         | best_row_o, best_col_o, status_o, last_o
//  apb     | slave     | psel/penable/pready     | paddr, pwrite, pwdata, prdata
//
// an append transaction is accepted while idle; an align runs border set-up of the top row
// after the accepting cycle, then the fill (each cell a read state and a calc state through
// the shared scoring unit and the single-port row memory), the traceback (a read and an act
// state per step, plus a split state for a mismatch on the diagonal) and the emitter (a read
// and a load state per column, held by any output stall). in_ready_o is low for the whole align.
// rst_ni clears counters, control and the configuration registers at once; the stores need no clearing.
// a stalled output holds its register; new input waits until that register is free.
module global_sequence_aligner_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input item channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 req_type_i,
  input  logic [1:0]                 base_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 col_long_o,
  output logic [2:0]                 col_short_o,
  output gsa_pkg::score_t            best_score_o,
  output logic [gsa_pkg::LEN_W-1:0]  best_row_o,
  output logic [gsa_pkg::LEN_W-1:0]  best_col_o,
  output logic [1:0]                 status_o,
  output logic                       last_o,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gsa_pkg::APB_AW-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);
  import gsa_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE        = 9'b000000001,
    S_ROW_INIT    = 9'b000000010,
    S_FILL_RD     = 9'b000000100,
    S_FILL_CALC   = 9'b000001000,
    S_TRACE_RD    = 9'b000010000,
    S_TRACE_ACT   = 9'b000100000,
    S_TRACE_SPLIT = 9'b001000000,
    S_EMIT_RD     = 9'b010000000,
    S_EMIT_LD     = 9'b100000000
  } state_e;

  // configuration registers
  logic [6:0]  gap_q;
  logic [63:0] w_at_q, w_gc_q;
  logic        tb_last_q;
  logic        cfg_we;
  reg_idx_e    cfg_idx;

  // sequences and counts
  logic [1:0]       long_seq_q  [MAX_LEN];
  logic [1:0]       short_seq_q [MAX_LEN];
  logic [LEN_W-1:0] long_cnt_q, long_cnt_d, short_cnt_q, short_cnt_d;
  logic             long_we, short_we;

  // sequencer state
  state_e            state_q, state_d;
  logic [LEN_W-1:0]  len_l_q, len_l_d, len_s_q, len_s_d;
  logic [LEN_W-1:0]  r_q, r_d, c_q, c_d, r_m1, c_m1;
  score_t            acc_q, acc_d, col0_q, col0_d, diag_q, diag_d, left_q, left_d;
  score_t            best_q, best_d, g14;
  logic [LEN_W-1:0]  br_q, br_d, bc_q, bc_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [BUF_AW-1:0] idx_q, idx_d;

  // memories
  score_t            row_mem [MAX_LEN];
  score_t            row_rd_q;
  logic              row_we;
  logic [IDX_W-1:0]  row_wa;
  score_t            row_wd;
  dir_e              dir_mem [DIR_DEPTH];
  dir_e              dir_rd_q;
  logic              dir_we;
  logic [DIR_AW-1:0] dir_a;
  logic [5:0]        buf_mem [BUF_DEPTH];
  logic [5:0]        buf_rd_q;
  logic              buf_we;
  logic [5:0]        buf_wd;

  // output register
  logic             out_valid_q, out_load, out_free;
  logic [2:0]       col_long_q, col_long_d, col_short_q, col_short_d;
  score_t           best_score_q, best_score_d;
  logic [LEN_W-1:0] best_row_q, best_row_d, best_col_q, best_col_d;
  logic [1:0]       status_q, status_d;
  logic             last_q, last_d;

  // scoring unit
  cell_res_t         res;
  logic signed [7:0] weight;
  logic [1:0]        sb, lb;
  logic              take, in_acc;
  dir_e              mv;

  // ---------------------------------------------------------------------------
  // configuration port: always ready, decode on the 8-byte register slot
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[APB_AW-1:3]);

  always_comb begin
    unique case (cfg_idx)
      REG_GAP:    prdata = 64'(gap_q);
      REG_W_AT:   prdata = w_at_q;
      REG_W_GC:   prdata = w_gc_q;
      REG_TB_DIR: prdata = 64'(tb_last_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q     <= '0;
      w_at_q    <= W_AT_RESET;
      w_gc_q    <= W_GC_RESET;
      tb_last_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_GAP:    gap_q     <= pwdata[6:0];
        REG_W_AT:   w_at_q    <= pwdata;
        REG_W_GC:   w_gc_q    <= pwdata;
        REG_TB_DIR: tb_last_q <= pwdata[0];
        default:    ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // datapath helpers
  // ---------------------------------------------------------------------------
  assign g14      = score_t'(gap_q);
  assign r_m1     = r_q - 1'b1;
  assign c_m1     = c_q - 1'b1;
  assign sb       = short_seq_q[r_m1[IDX_W-1:0]];
  assign lb       = long_seq_q[c_m1[IDX_W-1:0]];
  assign weight   = weight_of(w_at_q, w_gc_q, sb, lb);
  assign dir_a    = {r_m1[IDX_W-1:0], c_m1[IDX_W-1:0]};
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_acc   = in_valid_i && in_ready_o;

  gsa_score_alu u_alu (
    .diag_i   (diag_q),
    .left_i   (left_q),
    .up_i     (row_rd_q),
    .weight_i (weight),
    .gap_i    (gap_q),
    .res_o    (res)
  );

  // first cell seeds the maximum; afterwards first or last maximum per mode
  assign take = (r_q == LEN_W'(1) && c_q == LEN_W'(1)) ||
                (tb_last_q ? (res.score >= best_q) : (res.score > best_q));

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    long_cnt_d   = long_cnt_q;
    short_cnt_d  = short_cnt_q;
    len_l_d      = len_l_q;
    len_s_d      = len_s_q;
    r_d          = r_q;
    c_d          = c_q;
    acc_d        = acc_q;
    col0_d       = col0_q;
    diag_d       = diag_q;
    left_d       = left_q;
    best_d       = best_q;
    br_d         = br_q;
    bc_d         = bc_q;
    pos_d        = pos_q;
    idx_d        = idx_q;
    long_we      = 1'b0;
    short_we     = 1'b0;
    row_we       = 1'b0;
    row_wa       = c_m1[IDX_W-1:0];
    row_wd       = acc_q;
    dir_we       = 1'b0;
    buf_we       = 1'b0;
    buf_wd       = {GAP_SYM, GAP_SYM};
    out_load     = 1'b0;
    col_long_d   = GAP_SYM;
    col_short_d  = GAP_SYM;
    best_score_d = '0;
    best_row_d   = '0;
    best_col_d   = '0;
    status_d     = ST_COLUMN;
    last_d       = 1'b1;
    mv           = DIR_UP;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (req_type_i)
            REQ_LONG: begin
              if (long_cnt_q == LEN_W'(MAX_LEN)) begin
                out_load = 1'b1;
                status_d = ST_OVERFLOW;
              end else begin
                long_we    = 1'b1;
                long_cnt_d = long_cnt_q + 1'b1;
              end
            end
            REQ_SHORT: begin
              if (short_cnt_q == LEN_W'(MAX_LEN)) begin
                out_load = 1'b1;
                status_d = ST_OVERFLOW;
              end else begin
                short_we    = 1'b1;
                short_cnt_d = short_cnt_q + 1'b1;
              end
            end
            REQ_ALIGN: begin
              long_cnt_d  = '0;
              short_cnt_d = '0;
              if (long_cnt_q == '0 || short_cnt_q == '0 || short_cnt_q > long_cnt_q) begin
                out_load = 1'b1;
                status_d = ST_BAD_LEN;
              end else begin
                len_l_d = long_cnt_q;
                len_s_d = short_cnt_q;
                c_d     = LEN_W'(1);
                acc_d   = -g14;
                state_d = S_ROW_INIT;
              end
            end
            default: ;
          endcase
        end
      end

      // top border row: row memory slot c-1 gets -c*gap
      S_ROW_INIT: begin
        row_we = 1'b1;
        acc_d  = acc_q - g14;
        c_d    = c_q + 1'b1;
        if (c_q == len_l_q) begin
          r_d     = LEN_W'(1);
          c_d     = LEN_W'(1);
          diag_d  = '0;
          left_d  = -g14;
          col0_d  = -g14;
          state_d = S_FILL_RD;
        end
      end

      S_FILL_RD: state_d = S_FILL_CALC;

      S_FILL_CALC: begin
        row_we = 1'b1;
        row_wd = res.score;
        dir_we = 1'b1;
        if (take) begin
          best_d = res.score;
          br_d   = r_q;
          bc_d   = c_q;
        end
        if (c_q == len_l_q) begin
          if (r_q == len_s_q) begin
            r_d     = br_d;
            c_d     = bc_d;
            pos_d   = '0;
            state_d = S_TRACE_RD;
          end else begin
            r_d     = r_q + 1'b1;
            c_d     = LEN_W'(1);
            diag_d  = col0_q;
            left_d  = col0_q - g14;
            col0_d  = col0_q - g14;
            state_d = S_FILL_RD;
          end
        end else begin
          c_d     = c_q + 1'b1;
          diag_d  = row_rd_q;
          left_d  = res.score;
          state_d = S_FILL_RD;
        end
      end

      S_TRACE_RD: begin
        if (r_q == '0 && c_q == '0) begin
          idx_d   = BUF_AW'(pos_q - 1'b1);
          state_d = S_EMIT_RD;
        end else begin
          state_d = S_TRACE_ACT;
        end
      end

      // entries go in backwards: {long symbol, short symbol}
      S_TRACE_ACT: begin
        if (r_q == '0) begin
          mv = DIR_LEFT;
        end else if (c_q == '0) begin
          mv = DIR_UP;
        end else begin
          mv = dir_rd_q;
        end
        buf_we  = 1'b1;
        pos_d   = pos_q + 1'b1;
        state_d = S_TRACE_RD;
        case (mv)
          DIR_DIAG: begin
            if (sb != lb) begin
              // mismatch on the diagonal splits into two gap columns
              buf_wd  = {1'b0, lb, GAP_SYM};
              state_d = S_TRACE_SPLIT;
            end else begin
              buf_wd = {1'b0, lb, 1'b0, sb};
              r_d    = r_q - 1'b1;
              c_d    = c_q - 1'b1;
            end
          end
          DIR_LEFT: begin
            buf_wd = {1'b0, lb, GAP_SYM};
            c_d    = c_q - 1'b1;
          end
          DIR_UP: begin
            buf_wd = {GAP_SYM, 1'b0, sb};
            r_d    = r_q - 1'b1;
          end
          default: begin
            buf_we = 1'b0;
            pos_d  = pos_q;
          end
        endcase
      end

      S_TRACE_SPLIT: begin
        buf_we  = 1'b1;
        buf_wd  = {GAP_SYM, 1'b0, sb};
        pos_d   = pos_q + 1'b1;
        r_d     = r_q - 1'b1;
        c_d     = c_q - 1'b1;
        state_d = S_TRACE_RD;
      end

      S_EMIT_RD: state_d = S_EMIT_LD;

      // read the buffer backwards so columns leave in forward order
      S_EMIT_LD: begin
        if (out_free) begin
          out_load     = 1'b1;
          col_long_d   = buf_rd_q[5:3];
          col_short_d  = buf_rd_q[2:0];
          best_score_d = best_q;
          best_row_d   = br_q;
          best_col_d   = bc_q;
          status_d     = ST_COLUMN;
          last_d       = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = S_EMIT_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      long_cnt_q  <= '0;
      short_cnt_q <= '0;
      len_l_q     <= '0;
      len_s_q     <= '0;
      r_q         <= '0;
      c_q         <= '0;
      pos_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      long_cnt_q  <= long_cnt_d;
      short_cnt_q <= short_cnt_d;
      len_l_q     <= len_l_d;
      len_s_q     <= len_s_d;
      r_q         <= r_d;
      c_q         <= c_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    col0_q <= col0_d;
    diag_q <= diag_d;
    left_q <= left_d;
    best_q <= best_d;
    br_q   <= br_d;
    bc_q   <= bc_d;
    if (long_we) begin
      long_seq_q[long_cnt_q[IDX_W-1:0]] <= base_i;
    end
    if (short_we) begin
      short_seq_q[short_cnt_q[IDX_W-1:0]] <= base_i;
    end
    if (out_load) begin
      col_long_q   <= col_long_d;
      col_short_q  <= col_short_d;
      best_score_q <= best_score_d;
      best_row_q   <= best_row_d;
      best_col_q   <= best_col_d;
      status_q     <= status_d;
      last_q       <= last_d;
    end
  end

  // row memory: previous row of scores
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    if (state_q == S_FILL_RD) begin
      row_rd_q <= row_mem[c_m1[IDX_W-1:0]];
    end
  end

  // direction memory: winning move of every filled cell
  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_a] <= res.dir;
    end
    if (state_q == S_TRACE_RD) begin
      dir_rd_q <= dir_mem[dir_a];
    end
  end

  // alignment buffer
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[pos_q[BUF_AW-1:0]] <= buf_wd;
    end
    if (state_q == S_EMIT_RD) begin
      buf_rd_q <= buf_mem[idx_q];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign col_long_o   = col_long_q;
  assign col_short_o  = col_short_q;
  assign best_score_o = best_score_q;
  assign best_row_o   = best_row_q;
  assign best_col_o   = best_col_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_fill_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL_CALC |-> (r_q != '0 && r_q <= len_s_q && c_q != '0 && c_q <= len_l_q))
    else $error("fill index outside the matrix");

  a_trace_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TRACE_ACT |-> (r_q != '0 || c_q != '0))
    else $error("traceback step at the origin");

  a_trace_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TRACE_RD && r_q == '0 && c_q == '0) |-> pos_q != '0)
    else $error("traceback ended with an empty buffer");

  a_column_not_gaps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_COLUMN) |-> !(col_long_o == GAP_SYM && col_short_o == GAP_SYM))
    else $error("alignment column holds two gaps");

endmodule
